/* rtl/core/cpd_pkg.sv */
// Shared types, codes and the fixed entry table of the checked parameter dictionary.
// No dependencies; every module of the block imports this package.
package cpd_pkg;

    localparam int unsigned NUM_ENTRIES = 15;
    localparam int unsigned TABLE_LEN   = 15;
    localparam int unsigned NUM_LOOK    = (NUM_ENTRIES < TABLE_LEN) ? NUM_ENTRIES : TABLE_LEN;
    localparam int unsigned ADDR_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    localparam logic [1:0] ACC_RD = 2'b01;
    localparam logic [1:0] ACC_WR = 2'b10;
    localparam logic [1:0] ACC_RW = 2'b11;

    typedef enum logic {
        FN_READ  = 1'b0,
        FN_WRITE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ENTRY = 2'd1,
        ST_DENIED   = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_DENIED = 2'd1,
        ERR_RANGE  = 2'd2
    } t_err;

    typedef struct packed {
        logic [15:0]        key;
        logic [7:0]         sub;
        logic [1:0]         acc;
        logic               live;
        logic signed [31:0] dflt;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_slot;

    // Result of the key match, handed from the decoder to the sequencer
    typedef struct packed {
        logic               hit;
        logic [ADDR_W-1:0]  slot;
        logic [1:0]         acc;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_lookup;

    function automatic t_slot mk_slot(input logic [15:0] key, input logic [7:0] sub,
                                      input logic [1:0] acc, input logic live,
                                      input logic signed [31:0] dflt,
                                      input logic signed [31:0] lo,
                                      input logic signed [31:0] hi);
        t_slot s;
        s.key  = key;
        s.sub  = sub;
        s.acc  = acc;
        s.live = live;
        s.dflt = dflt;
        s.lo   = lo;
        s.hi   = hi;
        return s;
    endfunction

    // Fixed dictionary table; slot 14 closes the table and never matches
    function automatic t_slot slot_at(input int unsigned idx);
        t_slot s;
        case (idx)
            0:  s = mk_slot(16'h4000, 8'd0, ACC_WR, 1'b1, 32'sd0,      32'sd10, 32'sd1000);
            1:  s = mk_slot(16'h4000, 8'd1, ACC_RW, 1'b1, 32'sd100,    32'sd0,  32'sd100);
            2:  s = mk_slot(16'h4000, 8'd2, ACC_RW, 1'b1, 32'sd0,      32'sd0,  32'sd2);
            3:  s = mk_slot(16'h4001, 8'd0, ACC_WR, 1'b1, 32'sd0,      32'sd1,  32'sd104000);
            4:  s = mk_slot(16'h4001, 8'd1, ACC_RW, 1'b1, 32'sd500,    32'sd1,  32'sd2000);
            5:  s = mk_slot(16'h4001, 8'd2, ACC_RW, 1'b1, 32'sd10,     32'sd0,  32'sd2000);
            6:  s = mk_slot(16'h4001, 8'd3, ACC_RW, 1'b1, 32'sd0,      32'sd0,  32'sd2);
            7:  s = mk_slot(16'h4002, 8'd0, ACC_WR, 1'b1, 32'sd0,      32'sd1,  32'sd104000);
            8:  s = mk_slot(16'h4002, 8'd1, ACC_RW, 1'b1, 32'sd0,      32'sd0,  32'sd1000);
            9:  s = mk_slot(16'h4002, 8'd2, ACC_RW, 1'b1, 32'sd500,    32'sd1,  32'sd2000);
            10: s = mk_slot(16'h4002, 8'd3, ACC_RW, 1'b1, 32'sd10,     32'sd0,  32'sd2000);
            11: s = mk_slot(16'h4003, 8'd0, ACC_WR, 1'b1, 32'sd0,      32'sd0,  32'sd250880);
            12: s = mk_slot(16'h4003, 8'd1, ACC_RW, 1'b1, 32'sd128000, 32'sd0,  32'sd500000);
            13: s = mk_slot(16'h4003, 8'd2, ACC_RW, 1'b1, 32'sd32000,  32'sd0,  32'sd256000);
            14: s = mk_slot(16'hFFFF, 8'd0, ACC_RD, 1'b0, 32'sd0,      32'sd0,  32'sd0);
            default: s = mk_slot(16'h0000, 8'd0, ACC_RD, 1'b0, 32'sd0, 32'sd0, 32'sd0);
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/checked_parameter_dictionary.sv */
// Checked parameter dictionary: top level with the access sequencer and sticky error.
// Instantiates cpd_lookup and cpd_store; depends on cpd_pkg.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: func; tdata: index, subindex, value
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser: status; tdata: read_data, last_error
//
// Each transfer runs through two states: on accept in S_IDLE the key is decoded and the memory
// read issued, then in S_EXEC the result is checked, written back and registered once the
// output register is free; the registered read of the value memory is why S_EXEC follows.
// Reset restores all entries to their table defaults at once and clears the sticky error.
// A stalled output holds the result; the next transfer is still taken into the memory read.
module checked_parameter_dictionary import cpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [15:0] entry_index, [23:16] entry_subindex,
                                        // [55:24] write_value
    input  logic [0:0]  s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] read_data, [33:32] last_error, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state             r_state;
    t_lookup            w_look;
    t_lookup            r_look;
    t_func              r_func;
    logic signed [31:0] r_wval;
    logic signed [31:0] w_rd_data;
    logic               w_accept;
    logic               w_out_free;
    logic               w_wr_en;
    t_status            n_status;
    t_err               n_err;
    logic signed [31:0] n_data;
    logic               r_out_valid;
    t_status            r_out_status;
    logic signed [31:0] r_out_data;
    t_err               r_err;

    cpd_lookup u_lookup (
        .i_key  (s_axis_tdata[15:0]),
        .i_sub  (s_axis_tdata[23:16]),
        .o_look (w_look)
    );

    cpd_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_look.slot),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_look.slot),
        .i_wr_data (r_wval)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_comb begin
        n_status = ST_NO_ENTRY;
        n_err    = r_err;
        n_data   = '0;
        w_wr_en  = 1'b0;
        if (r_look.hit) begin
            if (r_func == FN_READ) begin
                if ((r_look.acc & ACC_RD) == '0) begin
                    n_status = ST_DENIED;
                    n_err    = ERR_DENIED;
                end else begin
                    n_status = ST_OK;
                    n_data   = w_rd_data;
                end
            end else begin
                if ((r_look.acc & ACC_WR) == '0) begin
                    n_status = ST_DENIED;
                    n_err    = ERR_DENIED;
                end else if (r_wval < $signed(r_look.lo) || r_wval > $signed(r_look.hi)) begin
                    n_status = ST_RANGE;
                    n_err    = ERR_RANGE;
                end else begin
                    n_status = ST_OK;
                    // commit only when the result leaves for the output register
                    w_wr_en  = (r_state == S_EXEC) && w_out_free;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_err       <= ERR_NONE;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_err       <= n_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_look <= w_look;
            r_func <= t_func'(s_axis_tuser[0]);
            r_wval <= s_axis_tdata[55:24];
        end
        if (r_state == S_EXEC && w_out_free) begin
            r_out_status <= n_status;
            r_out_data   <= n_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {6'd0, r_err, r_out_data};

endmodule

/* rtl/core/cpd_lookup.sv */
// Key decoder: matches index/subindex against the fixed table, lowest slot wins.
// Depends on cpd_pkg for the table and the lookup struct.
module cpd_lookup import cpd_pkg::*; (
    input  logic [15:0] i_key,
    input  logic [7:0]  i_sub,
    output t_lookup     o_look
);

    t_slot s;

    always_comb begin
        o_look.hit  = 1'b0;
        o_look.slot = '0;
        o_look.acc  = '0;
        o_look.lo   = '0;
        o_look.hi   = '0;
        s           = '0;
        // scan downward so the lowest matching slot is the one left standing
        for (int i = NUM_LOOK - 1; i >= 0; i--) begin
            s = slot_at(i);
            if (s.live && s.key == i_key && s.sub == i_sub) begin
                o_look.hit  = 1'b1;
                o_look.slot = ADDR_W'(i);
                o_look.acc  = s.acc;
                o_look.lo   = s.lo;
                o_look.hi   = s.hi;
            end
        end
    end

endmodule

/* rtl/core/cpd_store.sv */
// Entry value memory with registered read and per-entry valid bits.
// An entry never written reads as its table default. Depends on cpd_pkg.
module cpd_store import cpd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output logic signed [31:0] o_rd_data,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  logic signed [31:0] i_wr_data
);

    logic signed [31:0]   r_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_vld;
    logic signed [31:0]   r_q;
    logic signed [31:0]   r_q_dflt;
    logic                 r_q_vld;
    t_slot                w_rd_slot;

    assign w_rd_slot = slot_at(32'(i_rd_addr));

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q      <= r_mem[i_rd_addr];
            r_q_dflt <= w_rd_slot.dflt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_q_vld ? r_q : r_q_dflt;

endmodule

/* dv/cpd_scoreboard.sv */
// Scoreboard for the checked parameter dictionary: watches both stream channels,
// predicts each reply from its own copy of the entry table and compares per field.
// Depends on cpd_pkg for the operation, status and error codes.
module cpd_scoreboard import cpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_s_tdata,    // [15:0] entry_index, [23:16] entry_subindex,
                                      // [55:24] write_value
    input  logic [0:0]  i_s_tuser,    // [0] func
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,    // [31:0] read_data, [33:32] last_error
    input  logic [1:0]  i_m_tuser,    // [1:0] status
    output int          o_fail_count,
    output int          o_pending,
    output int          o_replies,
    output int          o_rejects
);

    localparam int unsigned DEF_COUNT = 15;

    typedef struct packed {
        logic [15:0]        key;
        logic [7:0]         sub;
        logic [1:0]         acc;
        logic               live;
        logic signed [31:0] dflt;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } param_def_t;

    typedef struct packed {
        t_status     status;
        logic [31:0] read_data;
        t_err        last_error;
    } dict_reply_t;

    dict_reply_t pending_replies[$];
    logic [31:0] param_values [NUM_ENTRIES];
    t_err        sticky_err;

    // Dictionary layout: four parameter groups, plus a closing slot that never matches
    function automatic param_def_t param_def(input int idx);
        param_def_t d;
        case (idx)
            0:  d = {16'h4000, 8'd0, ACC_WR, 1'b1, 32'sd0,      32'sd10, 32'sd1000};
            1:  d = {16'h4000, 8'd1, ACC_RW, 1'b1, 32'sd100,    32'sd0,  32'sd100};
            2:  d = {16'h4000, 8'd2, ACC_RW, 1'b1, 32'sd0,      32'sd0,  32'sd2};
            3:  d = {16'h4001, 8'd0, ACC_WR, 1'b1, 32'sd0,      32'sd1,  32'sd104000};
            4:  d = {16'h4001, 8'd1, ACC_RW, 1'b1, 32'sd500,    32'sd1,  32'sd2000};
            5:  d = {16'h4001, 8'd2, ACC_RW, 1'b1, 32'sd10,     32'sd0,  32'sd2000};
            6:  d = {16'h4001, 8'd3, ACC_RW, 1'b1, 32'sd0,      32'sd0,  32'sd2};
            7:  d = {16'h4002, 8'd0, ACC_WR, 1'b1, 32'sd0,      32'sd1,  32'sd104000};
            8:  d = {16'h4002, 8'd1, ACC_RW, 1'b1, 32'sd0,      32'sd0,  32'sd1000};
            9:  d = {16'h4002, 8'd2, ACC_RW, 1'b1, 32'sd500,    32'sd1,  32'sd2000};
            10: d = {16'h4002, 8'd3, ACC_RW, 1'b1, 32'sd10,     32'sd0,  32'sd2000};
            11: d = {16'h4003, 8'd0, ACC_WR, 1'b1, 32'sd0,      32'sd0,  32'sd250880};
            12: d = {16'h4003, 8'd1, ACC_RW, 1'b1, 32'sd128000, 32'sd0,  32'sd500000};
            13: d = {16'h4003, 8'd2, ACC_RW, 1'b1, 32'sd32000,  32'sd0,  32'sd256000};
            14: d = {16'hFFFF, 8'd0, ACC_RD, 1'b0, 32'sd0,      32'sd0,  32'sd0};
            default: d = {16'h0000, 8'd0, ACC_RD, 1'b0, 32'sd0, 32'sd0,  32'sd0};
        endcase
        return d;
    endfunction

    function automatic void load_defaults();
        param_def_t d;
        int         i;
        for (i = 0; i < NUM_ENTRIES; i++) begin
            d = param_def(i);
            param_values[i] = (i < DEF_COUNT) ? d.dflt : 32'd0;
        end
        sticky_err = ERR_NONE;
    endfunction

    // Resolve the key (lowest slot wins), check rights and limits, update the store
    function automatic dict_reply_t apply_access(input t_func fn, input logic [15:0] key,
                                                 input logic [7:0] sub,
                                                 input logic signed [31:0] wval);
        dict_reply_t        r;
        param_def_t         d;
        logic signed [31:0] lo_lim;
        logic signed [31:0] hi_lim;
        int                 hit;
        int                 i;
        hit = -1;
        for (i = 0; i < NUM_ENTRIES && i < DEF_COUNT; i++) begin
            d = param_def(i);
            if (hit < 0 && d.live && d.key == key && d.sub == sub)
                hit = i;
        end
        r.status    = ST_NO_ENTRY;
        r.read_data = '0;
        if (hit >= 0) begin
            d      = param_def(hit);
            lo_lim = d.lo;
            hi_lim = d.hi;
            if (fn == FN_READ) begin
                if ((d.acc & ACC_RD) == 2'b00) begin
                    r.status   = ST_DENIED;
                    sticky_err = ERR_DENIED;
                end else begin
                    r.status    = ST_OK;
                    r.read_data = param_values[hit];
                end
            end else if ((d.acc & ACC_WR) == 2'b00) begin
                r.status   = ST_DENIED;
                sticky_err = ERR_DENIED;
            end else if (wval < lo_lim || wval > hi_lim) begin
                r.status   = ST_RANGE;
                sticky_err = ERR_RANGE;
            end else begin
                r.status          = ST_OK;
                param_values[hit] = wval;
            end
        end
        r.last_error = sticky_err;
        return r;
    endfunction

    function automatic void check_reply();
        dict_reply_t want;
        o_replies++;
        if (i_m_tuser != ST_OK)
            o_rejects++;
        if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply, status %0d data %h error %0d", $time,
                     i_m_tuser, i_m_tdata[31:0], i_m_tdata[33:32]);
            o_fail_count++;
            return;
        end
        want = pending_replies.pop_front();
        if (i_m_tuser != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, i_m_tuser);
            o_fail_count++;
        end
        if (i_m_tdata[31:0] != want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     i_m_tdata[31:0]);
            o_fail_count++;
        end
        if (i_m_tdata[33:32] != want.last_error) begin
            $display("%0t: last_error expected %0d actual %0d", $time, want.last_error,
                     i_m_tdata[33:32]);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_defaults();
            pending_replies.delete();
            o_fail_count = 0;
            o_replies    = 0;
            o_rejects    = 0;
        end else begin
            // Retire the reply first: it always belongs to an earlier transfer
            if (i_m_tvalid && i_m_tready)
                check_reply();
            if (i_s_tvalid && i_s_tready)
                pending_replies.push_back(apply_access(t_func'(i_s_tuser[0]),
                                                       i_s_tdata[15:0], i_s_tdata[23:16],
                                                       i_s_tdata[55:24]));
        end
        o_pending = pending_replies.size();
    end

endmodule

/* dv/checked_parameter_dictionary_tb.sv */
// Top of the checked parameter dictionary testbench: clock, reset, access stimulus
// with bursty sender and stalling receiver, and the verdict.
// Depends on cpd_pkg, the block and cpd_scoreboard.
module checked_parameter_dictionary_tb;
    import cpd_pkg::*;

    typedef enum int {
        RX_STREAM,
        RX_COIN,
        RX_SLOW,
        RX_TOGGLE
    } rx_mode_t;

    localparam int RANDOM_ACCESSES = 850;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;    // [15:0] entry_index, [23:16] entry_subindex,
                                        // [55:24] write_value
    logic [0:0]  s_axis_tuser  = '0;    // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [31:0] read_data, [33:32] last_error
    logic [1:0]  m_axis_tuser;          // [1:0] status

    int       fail_count;
    int       pending_count;
    int       reply_count;
    int       reject_count;
    int       burst_left  = 0;
    int       read_count  = 0;
    int       write_count = 0;
    int       directed_count;
    rx_mode_t rx_mode     = RX_STREAM;
    int       rx_left     = 0;

    t_func       rnd_fn;
    logic [15:0] rnd_idx;
    logic [7:0]  rnd_sub;
    int          grp;
    int          roll;
    int          n;

    always #4 i_clk = ~i_clk;

    checked_parameter_dictionary u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cpd_scoreboard u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_replies    (reply_count),
        .o_rejects    (reject_count)
    );

    // Receiver: switch between free flow, coin flip, mostly stalled and toggling
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 160);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STREAM: m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SLOW:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= ~m_axis_tready;
        endcase
    end

    // Hold one transfer until accepted; drop valid between bursts unless the gap is zero
    task automatic send_access(input t_func fn, input logic [15:0] idx,
                               input logic [7:0] sub, input logic [31:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, sub, idx};
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        if (fn == FN_READ)
            read_count++;
        else
            write_count++;
    endtask

    // Values clustered on the entry limits, plus wide and extreme ones
    function automatic logic [31:0] pick_value();
        int          sel;
        logic [31:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            case ($urandom_range(0, 10))
                0:       v = 32'd0;
                1:       v = 32'd1;
                2:       v = 32'd2;
                3:       v = 32'd10;
                4:       v = 32'd100;
                5:       v = 32'd1000;
                6:       v = 32'd2000;
                7:       v = 32'd104000;
                8:       v = 32'd250880;
                9:       v = 32'd256000;
                default: v = 32'd500000;
            endcase
            v = v + $urandom_range(0, 2) - 1;
        end else if (sel < 55) begin
            v = $urandom_range(0, 2000);
        end else if (sel < 70) begin
            v = $urandom_range(0, 520000);
        end else if (sel < 80) begin
            case ($urandom_range(0, 3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'hFFFF_FFFF;
                default: v = -$urandom_range(1, 1000);
            endcase
        end else begin
            v = $urandom();
        end
        return v;
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults, write-only denial, limit edges, no-match keys, sticky error changes
        send_access(FN_READ,  16'h4000, 8'd1, 32'd0);
        send_access(FN_READ,  16'h4000, 8'd0, 32'd0);
        send_access(FN_WRITE, 16'h4000, 8'd0, 32'd10);
        send_access(FN_WRITE, 16'h4000, 8'd0, 32'd9);
        send_access(FN_WRITE, 16'h4000, 8'd0, 32'd1000);
        send_access(FN_WRITE, 16'h4000, 8'd0, 32'd1001);
        send_access(FN_WRITE, 16'h4000, 8'd1, 32'd0);
        send_access(FN_READ,  16'h4000, 8'd1, 32'd0);
        send_access(FN_READ,  16'hFFFF, 8'd0, 32'd0);
        send_access(FN_WRITE, 16'hFFFF, 8'd0, 32'h7FFF_FFFF);
        send_access(FN_READ,  16'h0000, 8'd0, 32'd0);
        send_access(FN_READ,  16'h4003, 8'hFF, 32'd0);
        send_access(FN_WRITE, 16'h4003, 8'd1, 32'h8000_0000);
        send_access(FN_WRITE, 16'h4003, 8'd1, 32'h7FFF_FFFF);
        send_access(FN_WRITE, 16'h4003, 8'd1, 32'd500000);
        send_access(FN_READ,  16'h4003, 8'd1, 32'hFFFF_FFFF);
        send_access(FN_WRITE, 16'h4003, 8'd0, 32'd250880);
        send_access(FN_READ,  16'h4003, 8'd0, 32'd0);
        send_access(FN_WRITE, 16'h4002, 8'd2, 32'd0);
        send_access(FN_WRITE, 16'h4001, 8'd3, 32'd2);
        send_access(FN_READ,  16'h4001, 8'd3, 32'd0);
        send_access(FN_READ,  16'h4003, 8'd2, 32'd0);
        send_access(FN_READ,  16'h4002, 8'd3, 32'd0);
        directed_count = read_count + write_count;

        for (n = 0; n < RANDOM_ACCESSES; n++) begin
            rnd_fn = t_func'($urandom_range(0, 1));
            roll   = $urandom_range(0, 99);
            if (roll < 72) begin
                grp     = $urandom_range(0, 3);
                rnd_idx = 16'h4000 + 16'(grp);
                rnd_sub = 8'($urandom_range(0, (grp == 1 || grp == 2) ? 3 : 2));
            end else if (roll < 84) begin
                rnd_idx = 16'h4000 + 16'($urandom_range(0, 4));
                rnd_sub = 8'($urandom());
            end else if (roll < 88) begin
                rnd_idx = 16'hFFFF;
                rnd_sub = 8'd0;
            end else begin
                rnd_idx = 16'($urandom());
                rnd_sub = 8'($urandom());
            end
            send_access(rnd_fn, rnd_idx, rnd_sub, pick_value());
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d reads and %0d writes (%0d directed) with bursty input and stalls;",
                 read_count, write_count, directed_count);
        $display("checked %0d replies, %0d of them carrying an error status.",
                 reply_count, reject_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d replies outstanding", pending_count);
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/cpd_pkg.sv
rtl/core/cpd_lookup.sv
rtl/core/cpd_store.sv
rtl/core/checked_parameter_dictionary.sv
dv/cpd_scoreboard.sv
dv/checked_parameter_dictionary_tb.sv
